// File: rtl/core/ols_pkg.sv
package ols_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_LIST     = 3'd1,
    CMD_RM_HEAD  = 3'd2,
    CMD_RM_TAIL  = 3'd3,
    CMD_RM_AFTER = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LIST,
    S_SEARCH,
    S_SHIFT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    walk_init;   // read entry 0, next read at 1
    logic    walk;        // read next entry if any remain
    logic    shift_head;  // close gap at position 0
    logic    shift_match; // close gap after the matched entry
    logic    shift_wr;    // write returned entry one place lower
    logic    append;
    logic    dec_count;
    logic    emit;
    logic    emit_list;   // result carries the returned entry
    status_t status;
    logic    last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic rd_more;
    logic dvld;
    logic match;
    logic at_tail;
  } dp_stat_t;

endpackage

// File: rtl/core/ols_ram.sv
module ols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ols_dp.sv
module ols_dp #(
  parameter int DEPTH = ols_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic signed [ols_pkg::DATA_W-1:0]  in_value,
  input  ols_pkg::dp_cmd_t                   cmd,
  output ols_pkg::dp_stat_t                  stat,
  output logic                               out_strobe,
  output logic signed [ols_pkg::DATA_W-1:0]  out_value_res,
  output logic [ols_pkg::STAT_W-1:0]         out_status,
  output logic                               out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ols_pkg::DATA_W-1:0] key_r, key_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              rptr_r, rptr_nxt;
  logic [IW-1:0]              dptr_r, dptr_nxt;
  logic                       dvld_r, dvld_nxt;
  logic                       ostb_r, ostb_nxt;
  logic [ols_pkg::DATA_W-1:0] oval_r, oval_nxt;
  logic [ols_pkg::STAT_W-1:0] ostat_r, ostat_nxt;
  logic                       olast_r, olast_nxt;

  logic                       rd_more;
  logic                       rd_en;
  logic [IW-1:0]              raddr;
  logic                       we;
  logic [IW-1:0]              waddr;
  logic [ols_pkg::DATA_W-1:0] wdata;
  logic [ols_pkg::DATA_W-1:0] rdata;

  ols_ram #(
    .WIDTH (ols_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_more = rptr_r < count_r;

  always_comb begin
    rd_en = cmd.walk_init | (cmd.walk & rd_more);
    raddr = cmd.walk_init ? '0 : rptr_r[IW-1:0];
    we    = 1'b0;
    waddr = count_r[IW-1:0];
    wdata = key_r;
    if (cmd.append) begin
      we = 1'b1;
    end else if (cmd.shift_wr && dvld_r) begin
      we    = 1'b1;
      waddr = dptr_r - IW'(1);
      wdata = rdata;
    end
  end

  always_comb begin
    key_nxt   = load ? in_value : key_r;
    count_nxt = count_r;
    if (cmd.append) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
    rptr_nxt = rptr_r;
    if (cmd.walk_init || cmd.shift_head) begin
      rptr_nxt = CW'(1);
    end else if (cmd.shift_match) begin
      rptr_nxt = CW'(dptr_r) + CW'(2);
    end else if (rd_en) begin
      rptr_nxt = rptr_r + CW'(1);
    end
    dvld_nxt  = rd_en;
    dptr_nxt  = rd_en ? raddr : dptr_r;
    ostb_nxt  = cmd.emit;
    oval_nxt  = cmd.emit_list ? rdata : '0;
    ostat_nxt = cmd.status;
    olast_nxt = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rptr_r  <= '0;
      dvld_r  <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rptr_r  <= rptr_nxt;
      dvld_r  <= dvld_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    dptr_r  <= dptr_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    stat.empty   = count_r == '0;
    stat.full    = count_r == CW'(DEPTH);
    stat.rd_more = rd_more;
    stat.dvld    = dvld_r;
    stat.match   = dvld_r && (rdata == key_r);
    stat.at_tail = CW'(dptr_r) == (count_r - CW'(1));
  end

  assign out_strobe    = ostb_r;
  assign out_value_res = oval_r;
  assign out_status    = ostat_r;
  assign out_last      = olast_r;

endmodule

// File: rtl/core/ols_ctrl.sv
module ols_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ols_pkg::CMD_W-1:0]   in_command,
  input  ols_pkg::dp_stat_t           stat,
  output ols_pkg::dp_cmd_t            cmd,
  output logic                        load,
  output logic                        busy
);

  ols_pkg::state_t            state_r, state_nxt;
  logic [ols_pkg::CMD_W-1:0]  opc_r, opc_nxt;

  assign busy = state_r != ols_pkg::S_IDLE;
  assign load = start && !busy;

  always_comb begin
    state_nxt = state_r;
    opc_nxt   = load ? in_command : opc_r;
    case (state_r)
      ols_pkg::S_IDLE: begin
        if (load) begin
          state_nxt = ols_pkg::S_DISPATCH;
        end
      end
      ols_pkg::S_DISPATCH: begin
        state_nxt = ols_pkg::S_IDLE;
        case (opc_r)
          ols_pkg::CMD_LIST: begin
            if (!stat.empty) state_nxt = ols_pkg::S_LIST;
          end
          ols_pkg::CMD_RM_HEAD: begin
            if (!stat.empty) state_nxt = ols_pkg::S_SHIFT;
          end
          ols_pkg::CMD_RM_AFTER: begin
            if (!stat.empty) state_nxt = ols_pkg::S_SEARCH;
          end
          default: state_nxt = ols_pkg::S_IDLE;
        endcase
      end
      ols_pkg::S_LIST: begin
        if (stat.dvld && stat.at_tail) state_nxt = ols_pkg::S_IDLE;
      end
      ols_pkg::S_SEARCH: begin
        if (stat.dvld) begin
          if (stat.at_tail) begin
            state_nxt = ols_pkg::S_IDLE;
          end else if (stat.match) begin
            state_nxt = ols_pkg::S_SHIFT;
          end
        end
      end
      ols_pkg::S_SHIFT: begin
        if (!stat.dvld && !stat.rd_more) state_nxt = ols_pkg::S_IDLE;
      end
      default: state_nxt = ols_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = ols_pkg::ST_OK;
    case (state_r)
      ols_pkg::S_DISPATCH: begin
        case (opc_r)
          ols_pkg::CMD_APPEND: begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.append = !stat.full;
            if (stat.full) cmd.status = ols_pkg::ST_FULL;
          end
          ols_pkg::CMD_LIST, ols_pkg::CMD_RM_AFTER: begin
            if (stat.empty) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = ols_pkg::ST_EMPTY;
            end else begin
              cmd.walk_init = 1'b1;
            end
          end
          ols_pkg::CMD_RM_HEAD: begin
            if (stat.empty) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = ols_pkg::ST_EMPTY;
            end else begin
              cmd.shift_head = 1'b1;
            end
          end
          ols_pkg::CMD_RM_TAIL: begin
            cmd.emit      = 1'b1;
            cmd.last      = 1'b1;
            cmd.dec_count = !stat.empty;
            if (stat.empty) cmd.status = ols_pkg::ST_EMPTY;
          end
          default: cmd = cmd;
        endcase
      end
      ols_pkg::S_LIST: begin
        cmd.walk      = 1'b1;
        cmd.emit      = stat.dvld;
        cmd.emit_list = 1'b1;
        cmd.last      = stat.at_tail;
      end
      ols_pkg::S_SEARCH: begin
        if (stat.dvld && stat.at_tail) begin
          // key absent, or first match sits at the tail
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.status = ols_pkg::ST_MISS;
        end else if (stat.match) begin
          cmd.shift_match = 1'b1;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ols_pkg::S_SHIFT: begin
        cmd.walk     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (!stat.dvld && !stat.rd_more) begin
          cmd.dec_count = 1'b1;
          cmd.emit      = 1'b1;
          cmd.last      = 1'b1;
        end
      end
      default: cmd = cmd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ols_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opc_r <= opc_nxt;
  end

endmodule

// File: rtl/core/ordered_list_store_core.sv
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+---------------------------
// input    | in_command, in_value                       | start high, busy low
// result   | out_value_res, out_status, out_last        | out_strobe, one cycle each
//
// Append and remove tail issue their result beat in the dispatch state, through the output register.
// List gives one beat per entry, one beat per cycle, head first.
// Remove head and remove after walk the RAM's single read port, one entry a cycle:
// search and gap closing touch each entry at most once.
// Synchronous reset empties the list; the RAM itself is not cleared.
// Result beats cannot be held off; the next command may start while the final beat shows.
module ordered_list_store_core #(
  parameter int DEPTH = ols_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ols_pkg::CMD_W-1:0]          in_command,
  input  logic signed [ols_pkg::DATA_W-1:0]  in_value,
  output logic                               out_strobe,
  output logic signed [ols_pkg::DATA_W-1:0]  out_value_res,
  output logic [ols_pkg::STAT_W-1:0]         out_status,
  output logic                               out_last
);

  ols_pkg::dp_cmd_t  dp_cmd;
  ols_pkg::dp_stat_t dp_stat;
  logic              load;

  ols_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (dp_stat),
    .cmd        (dp_cmd),
    .load       (load),
    .busy       (busy)
  );

  ols_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .in_value      (in_value),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .out_strobe    (out_strobe),
    .out_value_res (out_value_res),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

// File: rtl/core/ols_checker.sv
module ols_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [ols_pkg::CMD_W-1:0]          in_command,
  input logic signed [ols_pkg::DATA_W-1:0]  in_value,
  input logic                               out_strobe,
  input logic signed [ols_pkg::DATA_W-1:0]  out_value_res,
  input logic [ols_pkg::STAT_W-1:0]         out_status,
  input logic                               out_last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after accepted command");

  // a listing streams its beats without gaps
  a_list_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a listing");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ols_pkg::ST_OK |-> out_last)
    else $error("error beat not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ols_pkg::ST_OK |-> out_value_res == '0)
    else $error("error beat carries a value");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("activity straight after reset");

endmodule

bind ordered_list_store_core ols_checker u_ols_checker (.*);
